// ===== rtl/hso_pkg.sv =====
`timescale 1ns / 1ps

package hso_pkg;

  // Field widths
  localparam int KNOB_W   = 16;
  localparam int POT_W    = 16;
  localparam int SPH_W    = 20;
  localparam int SAMPLE_W = 24;

  // Step register reset value (2^32 / 48000)
  localparam logic [SPH_W-1:0] SPH_RESET = 20'd89478;

  // Frequency knob full scale, Hz
  localparam int MAX_FREQ_HZ = 10000;
  // 22 Hz floor in Q16.16
  localparam logic [30:0] MIN_FREQ_Q16 = 31'd1441792;

  // Pot end stops: 0.01 and 0.9 in Q0.16
  localparam logic [POT_W-1:0] LEVEL_MIN = 16'd655;
  localparam logic [POT_W-1:0] LEVEL_MAX = 16'd58982;

  // Datapath widths
  localparam int A_W   = 33;  // signed multiplier operand A
  localparam int B_W   = 27;  // unsigned multiplier operand B
  localparam int P_W   = 61;  // signed product
  localparam int ACC_W = 47;  // mix accumulator
  localparam int U_W   = 30;  // rounded mix / 2^16
  localparam int Q_W   = 24;  // quotient magnitude

  // Divide by 52: reciprocal floor(2^32/52), rounding offset 26*2^16
  localparam logic [B_W-1:0]   RECIP_52   = 27'd82595524;
  localparam logic [ACC_W-1:0] ROUND_HALF = 47'd1703936;
  localparam logic [6:0]       DIV_52     = 7'd52;

  localparam logic [B_W-1:0] MAXF_B = B_W'(MAX_FREQ_HZ);

  // Sequencer step counter
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_DONE = 4'd14;

  // Operand A select
  localparam logic [2:0] A_KNOB = 3'd0;
  localparam logic [2:0] A_FREQ = 3'd1;
  localparam logic [2:0] A_PH1  = 3'd2;
  localparam logic [2:0] A_PH2  = 3'd3;
  localparam logic [2:0] A_PH3  = 3'd4;
  localparam logic [2:0] A_ROM  = 3'd5;
  localparam logic [2:0] A_U    = 3'd6;

  // Operand B select
  localparam logic [2:0] B_MAXF  = 3'd0;
  localparam logic [2:0] B_SPH   = 3'd1;
  localparam logic [2:0] B_DEPTH = 3'd2;
  localparam logic [2:0] B_LEV2  = 3'd3;
  localparam logic [2:0] B_LEV3  = 3'd4;
  localparam logic [2:0] B_RECIP = 3'd5;

  // Accumulator ops
  localparam logic [1:0] ACC_HOLD  = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_ADD15 = 2'd2;
  localparam logic [1:0] ACC_ADD12 = 2'd3;

  // Jump kinds
  localparam logic [1:0] J_NEXT   = 2'd0;  // fall through
  localparam logic [1:0] J_WAIT   = 2'd1;  // hold until a word is taken
  localparam logic [1:0] J_BRANCH = 2'd2;  // go to target when remainder is low
  localparam logic [1:0] J_DONE   = 2'd3;  // emit, hold while output is full

  // One microcode word
  typedef struct packed {
    logic [2:0]      a_sel;
    logic [2:0]      b_sel;
    logic            mul_en;
    logic [1:0]      acc_op;
    logic            step_ld;
    logic            u_ld;
    logic            q_ld;
    logic            q_inc;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Conditions seen by the sequencer
  typedef struct packed {
    logic start;
    logic rem_low;
    logic out_busy;
  } stat_t;

  // Pot code to level, end stops pulled in
  function automatic logic [POT_W-1:0] pot_level(logic [POT_W-1:0] code);
    if (code == '0) begin
      return LEVEL_MIN;
    end else if (code == '1) begin
      return LEVEL_MAX;
    end
    return code;
  endfunction

endpackage

// ===== rtl/hso_if.sv =====
`timescale 1ns / 1ps

// Input channel: one tick of knob and pot codes
interface hso_in_if
  import hso_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KNOB_W-1:0] freq_knob;
  logic [POT_W-1:0]  second_level_pot;
  logic [POT_W-1:0]  third_level_pot;

  modport source (output valid, freq_knob, second_level_pot, third_level_pot,
                  input ready);
  modport sink (input valid, freq_knob, second_level_pot, third_level_pot,
                output ready);
endinterface

// Result channel: one mixed sample
interface hso_out_if
  import hso_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       cycle_wrapped;

  modport source (output valid, sample, cycle_wrapped, input ready);
  modport sink (input valid, sample, cycle_wrapped, output ready);
endinterface

// Config channel: step_per_hz write
interface hso_cfg_if
  import hso_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SPH_W-1:0] step_per_hz;

  modport source (output valid, step_per_hz, input ready);
  modport sink (input valid, step_per_hz, output ready);
endinterface

// ===== rtl/hso_sine_rom.sv =====
`timescale 1ns / 1ps

module hso_sine_rom
  import hso_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  output logic signed [SAMPLE_W-1:0] data_r
);

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint SAT_MAX     = 64'sd8388607;

  // Entry i: sine of i/DEPTH turns, Taylor series to x^11 on one quadrant
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(longint i);
    longint     t;
    longint     r;
    longint     x;
    longint     x2;
    longint     term;
    longint     v;
    logic [1:0] quad;
    t    = (i <<< 32) / DEPTH;
    quad = t[31:30];
    r    = t & 64'sh3FFF_FFFF;
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x    = (r * HALF_PI_Q30) >>> 30;
    x2   = (x * x) >>> 30;
    term = Q30_ONE;
    term = Q30_ONE - ((x2 * term) >>> 30) / 110;
    term = Q30_ONE - ((x2 * term) >>> 30) / 72;
    term = Q30_ONE - ((x2 * term) >>> 30) / 42;
    term = Q30_ONE - ((x2 * term) >>> 30) / 20;
    term = Q30_ONE - ((x2 * term) >>> 30) / 6;
    v    = (x * term) >>> 30;
    v    = (v + 64) >>> 7;
    if (v > SAT_MAX) begin
      v = SAT_MAX;
    end
    return quad[1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
  endfunction

  logic signed [SAMPLE_W-1:0] rom_w [DEPTH];

  // Table contents fixed at elaboration
  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic signed [SAMPLE_W-1:0] ENTRY = sine_entry(longint'(g));
    assign rom_w[g] = ENTRY;
  end

  // Registered read; out-of-range codes only occur on unused cycles
  always_ff @(posedge clk) begin
    if (int'(addr) < DEPTH) begin
      data_r <= rom_w[addr];
    end else begin
      data_r <= '0;
    end
  end

endmodule

// ===== rtl/hso_useq.sv =====
`timescale 1ns / 1ps

module hso_useq
  import hso_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  idle,
  output logic  emit
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;

  // Program: frequency, step, three lookups, mix, divide by 52, emit
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    case (pc)
      4'd0: begin
        c.jmp = J_WAIT;
      end
      4'd1: begin
        c.a_sel = A_KNOB; c.b_sel = B_MAXF; c.mul_en = 1'b1;
      end
      4'd2: begin
        c.a_sel = A_FREQ; c.b_sel = B_SPH; c.mul_en = 1'b1;
      end
      4'd3: begin
        c.step_ld = 1'b1;
        c.a_sel = A_PH1; c.b_sel = B_DEPTH; c.mul_en = 1'b1;
      end
      4'd4: begin
        c.a_sel = A_PH2; c.b_sel = B_DEPTH; c.mul_en = 1'b1;
      end
      4'd5: begin
        c.acc_op = ACC_LOAD;
        c.a_sel = A_PH3; c.b_sel = B_DEPTH; c.mul_en = 1'b1;
      end
      4'd6: begin
        c.a_sel = A_ROM; c.b_sel = B_LEV2; c.mul_en = 1'b1;
      end
      4'd7: begin
        c.acc_op = ACC_ADD15;
        c.a_sel = A_ROM; c.b_sel = B_LEV3; c.mul_en = 1'b1;
      end
      4'd8: begin
        c.acc_op = ACC_ADD12;
      end
      4'd9: begin
        c.u_ld = 1'b1;
      end
      4'd10: begin
        c.a_sel = A_U; c.b_sel = B_RECIP; c.mul_en = 1'b1;
      end
      4'd11: begin
        c.q_ld = 1'b1;
      end
      4'd12: begin
        c.jmp = J_BRANCH; c.target = PC_DONE;
      end
      4'd13: begin
        c.q_inc = 1'b1;
      end
      4'd14: begin
        c.jmp = J_DONE;
      end
      default: begin
        c.jmp = J_NEXT;
      end
    endcase
    return c;
  endfunction

  assign ctrl = ucode(pc_r);
  assign idle = (pc_r == PC_IDLE);
  assign emit = (ctrl.jmp == J_DONE) && !stat.out_busy;

  // Next step
  always_comb begin
    case (ctrl.jmp)
      J_NEXT:   pc_nxt = pc_r + 1'b1;
      J_WAIT:   pc_nxt = stat.start ? pc_r + 1'b1 : pc_r;
      J_BRANCH: pc_nxt = stat.rem_low ? ctrl.target : pc_r + 1'b1;
      J_DONE:   pc_nxt = stat.out_busy ? pc_r : PC_IDLE;
      default:  pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/hso_dpath.sv =====
`timescale 1ns / 1ps

module hso_dpath
  import hso_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_t                      ctrl,
  input  logic                       start,
  input  logic                       emit,
  input  logic [KNOB_W-1:0]          in_knob,
  input  logic [POT_W-1:0]           in_pot2,
  input  logic [POT_W-1:0]           in_pot3,
  input  logic                       cfg_we,
  input  logic [SPH_W-1:0]           cfg_data,
  output logic                       rem_low,
  output logic signed [SAMPLE_W-1:0] res_sample,
  output logic                       res_wrap
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam logic [B_W-1:0] DEPTH_B = B_W'(SINE_TABLE_DEPTH);

  // Architectural state
  logic [SPH_W-1:0] sph_r;
  logic [31:0]      phase_r;

  // Working registers
  logic [KNOB_W-1:0]        knob_r;
  logic [POT_W-1:0]         lev2_r;
  logic [POT_W-1:0]         lev3_r;
  logic signed [P_W-1:0]    prod_r;
  logic [31:0]              step_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [U_W-1:0]           u_r;
  logic                     neg_r;
  logic [Q_W-1:0]           q_r;

  logic signed [SAMPLE_W-1:0] sine_q;
  logic [IDX_W-1:0]           rom_addr;

  logic [30:0]             freq;
  logic [31:0]             phase3;
  logic signed [A_W-1:0]   a_op;
  logic [B_W-1:0]          b_op;
  logic signed [ACC_W-1:0] s1_ext;
  logic signed [ACC_W-1:0] p_ext;
  logic signed [ACC_W-1:0] acc_nxt;
  logic [ACC_W-1:0]        mag;
  logic [ACC_W-1:0]        u_sum;
  logic [U_W:0]            q52;
  logic [U_W:0]            rem;
  logic [32:0]             phase_sum;

  // Sine table, indexed by (phase_k * depth) >> 32
  assign rom_addr = prod_r[32 +: IDX_W];

  hso_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (sine_q)
  );

  // Frequency with 22 Hz floor, third phase multiple
  assign freq   = (prod_r[30:0] < MIN_FREQ_Q16) ? MIN_FREQ_Q16 : prod_r[30:0];
  assign phase3 = phase_r + {phase_r[30:0], 1'b0};

  // Operand muxes
  always_comb begin
    case (ctrl.a_sel)
      A_KNOB:  a_op = $signed({{(A_W-KNOB_W){1'b0}}, knob_r});
      A_FREQ:  a_op = $signed({2'b00, freq});
      A_PH1:   a_op = $signed({1'b0, phase_r});
      A_PH2:   a_op = $signed({1'b0, phase_r[30:0], 1'b0});
      A_PH3:   a_op = $signed({1'b0, phase3});
      A_ROM:   a_op = A_W'(sine_q);
      A_U:     a_op = $signed({{(A_W-U_W){1'b0}}, u_r});
      default: a_op = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_MAXF:  b_op = MAXF_B;
      B_SPH:   b_op = {{(B_W-SPH_W){1'b0}}, sph_r};
      B_DEPTH: b_op = DEPTH_B;
      B_LEV2:  b_op = {{(B_W-POT_W){1'b0}}, lev2_r};
      B_LEV3:  b_op = {{(B_W-POT_W){1'b0}}, lev3_r};
      B_RECIP: b_op = RECIP_52;
      default: b_op = '0;
    endcase
  end

  // Mix terms: s1*20*2^16, s2*g2*15, s3*g3*12
  assign s1_ext = ACC_W'(sine_q);
  assign p_ext  = $signed(prod_r[ACC_W-1:0]);

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD:  acc_nxt = (s1_ext <<< 20) + (s1_ext <<< 18);
      ACC_ADD15: acc_nxt = acc_r + (p_ext <<< 4) - p_ext;
      ACC_ADD12: acc_nxt = acc_r + (p_ext <<< 3) + (p_ext <<< 2);
      default:   acc_nxt = acc_r;
    endcase
  end

  // Round half away: (|t| + 26*2^16) >> 16, then divide by 52
  assign mag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign u_sum = mag + ROUND_HALF;

  // Quotient estimate is low by at most one
  assign q52     = ({{(U_W+1-Q_W){1'b0}}, q_r} << 5) + ({{(U_W+1-Q_W){1'b0}}, q_r} << 4)
                 + ({{(U_W+1-Q_W){1'b0}}, q_r} << 2);
  assign rem     = {1'b0, u_r} - q52;
  assign rem_low = (rem < (U_W+1)'(DIV_52));

  // Result and phase advance
  assign phase_sum  = {1'b0, phase_r} + {1'b0, step_r};
  assign res_wrap   = phase_sum[32];
  assign res_sample = neg_r ? $signed(~q_r + 1'b1) : $signed(q_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sph_r   <= SPH_RESET;
      phase_r <= '0;
    end else begin
      if (cfg_we) begin
        sph_r <= cfg_data;
      end
      if (emit) begin
        phase_r <= phase_sum[31:0];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (start) begin
      knob_r <= in_knob;
      lev2_r <= pot_level(in_pot2);
      lev3_r <= pot_level(in_pot3);
    end
    if (ctrl.mul_en) begin
      prod_r <= a_op * $signed({1'b0, b_op});
    end
    if (ctrl.step_ld) begin
      step_r <= prod_r[47:16];
    end
    acc_r <= acc_nxt;
    if (ctrl.u_ld) begin
      u_r   <= u_sum[16 +: U_W];
      neg_r <= acc_r[ACC_W-1];
    end
    if (ctrl.q_ld) begin
      q_r <= prod_r[32 +: Q_W];
    end else if (ctrl.q_inc) begin
      q_r <= q_r + 1'b1;
    end
  end

endmodule

// ===== rtl/harmonic_sine_oscillator.sv =====
`timescale 1ns / 1ps

// Harmonic sine oscillator: one sample per input word.
// in_ch takes a frequency knob code and two harmonic level pot codes; out_ch
// returns sin(p) + 0.75*g2*sin(2p) + 0.6*g3*sin(3p), scaled by 1/2.6, as Q1.23,
// with a flag when the 32-bit phase wrapped on this tick. The sample uses the
// phase held before this tick's advance.
// cfg_ch writes step_per_hz (phase units per Hz); it is always ready. The user
// must write it only while no word is in flight; the block does not enforce it.
// Flow: in_ch is ready only while the sequencer sits at its idle step. The
// microcode takes each word through one shared multiplier and one sine ROM
// port, at most one product per step, and a conditional quotient fix-up step.
// The output register holds a finished word while out_ch is stalled; the
// next word is still taken and computed, and the sequencer waits at its last
// step until the register frees up.
// Reset (rst_n low, synchronous) clears the phase, restores step_per_hz to
// 89478 and empties the output register.
module harmonic_sine_oscillator
  import hso_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  hso_in_if.sink           in_ch,
  hso_out_if.source        out_ch,
  hso_cfg_if.sink          cfg_ch
);

  ctrl_t ctrl;
  stat_t stat;
  logic  idle;
  logic  emit;
  logic  rem_low;
  logic  res_wrap;
  logic  signed [SAMPLE_W-1:0] res_sample;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       wrap_r;

  // Handshakes
  assign in_ch.ready   = idle;
  assign cfg_ch.ready  = 1'b1;
  assign stat.start    = in_ch.valid && idle;
  assign stat.rem_low  = rem_low;
  assign stat.out_busy = out_valid_r && !out_ch.ready;

  hso_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl),
    .idle  (idle),
    .emit  (emit)
  );

  hso_dpath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .start      (stat.start),
    .emit       (emit),
    .in_knob    (in_ch.freq_knob),
    .in_pot2    (in_ch.second_level_pot),
    .in_pot3    (in_ch.third_level_pot),
    .cfg_we     (cfg_ch.valid),
    .cfg_data   (cfg_ch.step_per_hz),
    .rem_low    (rem_low),
    .res_sample (res_sample),
    .res_wrap   (res_wrap)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sample_r <= res_sample;
      wrap_r   <= res_wrap;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample        = sample_r;
  assign out_ch.cycle_wrapped = wrap_r;

endmodule

// ===== rtl/hso_checker.sv =====
`timescale 1ns / 1ps

module hso_checker
  import hso_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample,
  input logic                       out_wrapped
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_wrapped))
    else $error("result word changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // One word in flight: input closes right after a take
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a take");

  // A fresh result only comes from the busy sequencer
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while sequencer idle");

endmodule

bind harmonic_sine_oscillator hso_checker u_hso_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_sample  (out_ch.sample),
  .out_wrapped (out_ch.cycle_wrapped)
);
